// ----- rtl/swr_pkg.sv -----
package swr_pkg;

	localparam int MAX_TERM_DEF   = 64;
	localparam int PRICE_BITS_DEF = 32;

	localparam int TERM_CFG_W = 7;
	localparam int RSI_W      = 15;

	localparam logic [TERM_CFG_W-1:0] TERM_RESET  = 7'd14;
	localparam logic [RSI_W-1:0]      RSI_NEUTRAL = 15'd12800;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUB,
		ST_ADD,
		ST_MUL,
		ST_DIV,
		ST_OUT
	} swr_state_t;

endpackage

// ----- rtl/sliding_window_rsi.sv -----
// Sliding-window RSI over a stream of closing prices.
// Input channel: in_valid / in_stall carry tick_price and series_start; a
// transaction takes place when in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall carry rsi_value (RSI times 256,
// truncated) and warmed_up, one result transaction per input transaction.
// Configuration: a transaction on cfg_valid / cfg_ready writes window_term and
// starts a new series. It is written only while the block is idle, and it goes
// ahead of an input transaction offered in the same cycle.
// Sequence: an input transaction passes through ST_SUB (the oldest difference
// leaves the sums), ST_ADD (the new one enters them), ST_MUL (numerator
// set-up), the divider and ST_OUT, which hands the result over; the next input
// is taken once the block is back in ST_IDLE. During warm-up or a flat window
// the divider is skipped. One item is in flight at a time; in_stall is high
// while it is worked on.
// The differences sit in a row of cells that shifts once for each new
// difference; the oldest difference always leaves from the first cell.
// Reset clears the counts, sums, previous price and term (to 14); the cells
// need no clearing since a cell is read only after it was written.
// When the receiver stalls, the result waits in the output register; the
// next item is still taken, and its result waits until the register is free.
module sliding_window_rsi import swr_pkg::*; #(
	parameter int MAX_TERM   = MAX_TERM_DEF,
	parameter int PRICE_BITS = PRICE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [TERM_CFG_W-1:0] window_term,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [PRICE_BITS-1:0] tick_price,
	input  logic                  series_start,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [RSI_W-1:0]      rsi_value,
	output logic                  warmed_up
);

	localparam int DIFF_W = PRICE_BITS + 1;
	localparam int SUM_W  = PRICE_BITS + $clog2(MAX_TERM);
	localparam int NUM_W  = SUM_W + RSI_W;
	localparam int TERM_W = $clog2(MAX_TERM + 1);
	localparam int CNT_W  = $clog2(MAX_TERM + 2);
	localparam int CMP_W  = (TERM_W > TERM_CFG_W) ? TERM_W : TERM_CFG_W;

	swr_state_t state_q, state_d;

	logic [TERM_CFG_W-1:0] term_q;
	logic [PRICE_BITS-1:0] prev_q;
	logic [CNT_W-1:0]      count_q;
	logic [SUM_W-1:0]      up_q;
	logic [SUM_W-1:0]      total_q;

	logic [DIFF_W-1:0]     d_s1;
	logic [DIFF_W-1:0]     old_s1;
	logic                  has_diff_s1;
	logic                  evict_s1;
	logic                  warmed_s1;
	logic                  neutral_q;
	logic                  neutral_d;

	logic                  out_valid_q;
	logic [RSI_W-1:0]      rsi_q;
	logic                  warm_q;

	logic                  in_take;
	logic                  cfg_take;
	logic                  div_start;
	logic                  out_load;
	logic                  div_done;
	logic [RSI_W-1:0]      div_quot;

	logic [CMP_W-1:0]      term_ext;
	logic [TERM_W-1:0]     eff_term;
	logic [CNT_W-1:0]      term_plus1;
	logic [CNT_W-1:0]      cnt_eff;
	logic [CNT_W-1:0]      cnt_next;
	logic                  has_diff;
	logic [DIFF_W-1:0]     new_d;
	logic [NUM_W-1:0]      num_ext;
	logic [NUM_W-1:0]      numerator;

	logic [DIFF_W-1:0]     cell_d [MAX_TERM];
	logic [MAX_TERM-1:0]   insert;

	logic [PRICE_BITS-1:0] up_new, mag_new, up_old, mag_old;
	logic [DIFF_W-1:0]     neg_new, neg_old;

	// A term of zero acts as one, a term past the window depth as the depth.
	assign term_ext = CMP_W'(term_q);
	always_comb begin
		if (term_ext == '0) begin
			eff_term = TERM_W'(1);
		end else if (term_ext > CMP_W'(MAX_TERM)) begin
			eff_term = TERM_W'(MAX_TERM);
		end else begin
			eff_term = TERM_W'(term_ext);
		end
	end
	assign term_plus1 = CNT_W'(eff_term) + 1'b1;

	assign in_take  = in_valid && !in_stall;
	assign cfg_take = cfg_valid && cfg_ready;

	assign cnt_eff  = series_start ? '0 : count_q;
	assign has_diff = cnt_eff != '0;
	assign cnt_next = (cnt_eff < term_plus1) ? cnt_eff + 1'b1 : cnt_eff;
	assign new_d    = {1'b0, tick_price} - {1'b0, prev_q};

	// Row of difference cells.
	for (genvar i = 0; i < MAX_TERM; i++) begin : g_cell
		assign insert[i] = eff_term == TERM_W'(i + 1);
		swr_cell #(
			.DIFF_W(DIFF_W)
		) u_cell (
			.clk     (clk),
			.shift_en(in_take && has_diff),
			.insert  (insert[i]),
			.new_d   (new_d),
			.next_d  ((i == MAX_TERM - 1) ? new_d : cell_d[(i + 1) % MAX_TERM]),
			.d_q     (cell_d[i])
		);
	end

	assign neg_new = '0 - d_s1;
	assign neg_old = '0 - old_s1;
	assign up_new  = d_s1[DIFF_W-1] ? '0 : d_s1[PRICE_BITS-1:0];
	assign mag_new = d_s1[DIFF_W-1] ? neg_new[PRICE_BITS-1:0] : d_s1[PRICE_BITS-1:0];
	assign up_old  = old_s1[DIFF_W-1] ? '0 : old_s1[PRICE_BITS-1:0];
	assign mag_old = old_s1[DIFF_W-1] ? neg_old[PRICE_BITS-1:0] : old_s1[PRICE_BITS-1:0];

	// 25600 is 2^14 + 2^13 + 2^10.
	assign num_ext   = NUM_W'(up_q);
	assign numerator = (num_ext << 14) + (num_ext << 13) + (num_ext << 10);

	// The sums are final once the state machine reaches ST_MUL.
	assign neutral_d = !warmed_s1 || (total_q == '0);

	swr_div #(
		.SUM_W(SUM_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(numerator),
		.divisor (total_q),
		.done    (div_done),
		.quotient(div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		cfg_ready = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall  = cfg_valid;
				cfg_ready = 1'b1;
				if (in_valid && !cfg_valid) begin
					state_d = ST_SUB;
				end
			end
			ST_SUB: begin
				state_d = ST_ADD;
			end
			ST_ADD: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				if (neutral_d) begin
					state_d = ST_OUT;
				end else begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Series control and running sums.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_q      <= TERM_RESET;
			prev_q      <= '0;
			count_q     <= '0;
			up_q        <= '0;
			total_q     <= '0;
			has_diff_s1 <= 1'b0;
			evict_s1    <= 1'b0;
			warmed_s1   <= 1'b0;
			neutral_q   <= 1'b0;
		end else begin
			if (cfg_take) begin
				term_q  <= window_term;
				count_q <= '0;
				up_q    <= '0;
				total_q <= '0;
			end else if (in_take) begin
				prev_q      <= tick_price;
				count_q     <= cnt_next;
				has_diff_s1 <= has_diff;
				evict_s1    <= cnt_eff >= term_plus1;
				warmed_s1   <= cnt_next >= term_plus1;
				if (series_start) begin
					up_q    <= '0;
					total_q <= '0;
				end
			end
			if (state_q == ST_SUB && evict_s1) begin
				up_q    <= up_q - SUM_W'(up_old);
				total_q <= total_q - SUM_W'(mag_old);
			end
			if (state_q == ST_ADD) begin
				if (has_diff_s1) begin
					up_q    <= up_q + SUM_W'(up_new);
					total_q <= total_q + SUM_W'(mag_new);
				end
			end
			if (state_q == ST_MUL) begin
				neutral_q <= neutral_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			d_s1   <= new_d;
			old_s1 <= cell_d[0];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsi_q  <= neutral_q ? RSI_NEUTRAL : div_quot;
			warm_q <= warmed_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign rsi_value = rsi_q;
	assign warmed_up = warm_q;

endmodule

// ----- rtl/swr_cell.sv -----
module swr_cell import swr_pkg::*; #(
	parameter int DIFF_W = PRICE_BITS_DEF + 1
) (
	input  logic              clk,
	input  logic              shift_en,
	input  logic              insert,
	input  logic [DIFF_W-1:0] new_d,
	input  logic [DIFF_W-1:0] next_d,
	output logic [DIFF_W-1:0] d_q
);

	// The insertion cell takes the new difference; the others take their
	// upstream neighbor, so the oldest difference always reaches cell zero.
	always_ff @(posedge clk) begin
		if (shift_en) begin
			d_q <= insert ? new_d : next_d;
		end
	end

endmodule

// ----- rtl/swr_div.sv -----
module swr_div import swr_pkg::*; #(
	parameter int SUM_W = 38
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [SUM_W+RSI_W-1:0] dividend,
	input  logic [SUM_W-1:0]       divisor,
	output logic                   done,
	output logic [RSI_W-1:0]       quotient
);

	localparam int CNT_W = $clog2(RSI_W);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(RSI_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] rem_q;
	logic [SUM_W-1:0] div_q;
	logic [RSI_W-1:0] low_q;
	logic [RSI_W-1:0] quot_q;
	logic [SUM_W:0]   trial;
	logic             fits;

	// Restoring division, one quotient bit per cycle. The dividend is below
	// divisor * 2^RSI_W, so the top part starts out smaller than the divisor.
	assign trial = {rem_q, low_q[RSI_W-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[SUM_W+RSI_W-1:RSI_W];
			low_q <= dividend[RSI_W-1:0];
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q  <= fits ? SUM_W'(trial - {1'b0, div_q}) : trial[SUM_W-1:0];
			low_q  <= {low_q[RSI_W-2:0], 1'b0};
			quot_q <= {quot_q[RSI_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule
